### design/sfc_pkg.sv
// Shared constants, operation and verdict codes, and lane flag type for the
// sphere frustum culling block. No dependencies.
`default_nettype none

package sfc_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;

    localparam int OP_WIDTH      = 3;
    localparam int PIDX_WIDTH    = 3;
    localparam int VERDICT_WIDTH = 2;

    localparam logic [OP_WIDTH-1:0] OP_LOAD_PLANE  = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_LOAD_CAMERA = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_SPHERE      = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_POINT       = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_GEOMETRY    = 3'd4;

    localparam logic [VERDICT_WIDTH-1:0] V_INSIDE    = 2'd0;
    localparam logic [VERDICT_WIDTH-1:0] V_INTERSECT = 2'd1;
    localparam logic [VERDICT_WIDTH-1:0] V_OUTSIDE   = 2'd2;

    // Per-plane comparison results of one distance against the radius.
    typedef struct packed {
        logic below;   // distance < -radius
        logic band;    // -radius < distance < radius
        logic neg;     // distance < 0
    } plane_flags_t;

endpackage

`default_nettype wire

### design/sfc_in_if.sv
// Input channel of the culling block: valid/ready handshake plus one item word.
// Depends on sfc_pkg for field widths.
`default_nettype none

interface sfc_in_if #(
    parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic [sfc_pkg::OP_WIDTH-1:0]      operation;
    logic [sfc_pkg::PIDX_WIDTH-1:0]    plane_index;
    logic signed [COORD_WIDTH-1:0]     coef_a;
    logic signed [COORD_WIDTH-1:0]     coef_b;
    logic signed [COORD_WIDTH-1:0]     coef_c;
    logic signed [COORD_WIDTH-1:0]     coef_d;
    logic signed [COORD_WIDTH-1:0]     pos_x;
    logic signed [COORD_WIDTH-1:0]     pos_y;
    logic signed [COORD_WIDTH-1:0]     pos_z;
    logic [COORD_WIDTH-2:0]            radius;

    modport source (
        output valid, operation, plane_index, coef_a, coef_b, coef_c, coef_d,
               pos_x, pos_y, pos_z, radius,
        input  ready
    );
    modport sink (
        input  valid, operation, plane_index, coef_a, coef_b, coef_c, coef_d,
               pos_x, pos_y, pos_z, radius,
        output ready
    );
endinterface

`default_nettype wire

### design/sfc_out_if.sv
// Result channel of the culling block: valid/ready handshake plus verdict word.
// Depends on sfc_pkg for the verdict width.
`default_nettype none

interface sfc_out_if ();
    logic                               valid;
    logic                               ready;
    logic [sfc_pkg::VERDICT_WIDTH-1:0]  verdict;
    logic                               is_test_result;

    modport source (
        output valid, verdict, is_test_result,
        input  ready
    );
    modport sink (
        input  valid, verdict, is_test_result,
        output ready
    );
endinterface

`default_nettype wire

### design/sphere_frustum_cull_top.sv
// Sphere/point frustum culling pipeline: one word in, one verdict word out per
// item; at full rate one item per cycle. Each cycle one lane per plane forms
// a signed distance exactly (3 multipliers per plane) and the camera check uses
// 7 more multipliers; these sit between four register stages that each word
// passes in turn. A waiting result stalls the whole pipeline. Plane and camera
// loads take effect for the next word accepted and answer verdict inside with
// is_test_result low.
// Depends on sfc_pkg, sfc_in_if, sfc_out_if and sfc_plane_lane.
`default_nettype none

module sphere_frustum_cull_top #(
    parameter int PLANE_COUNT = sfc_pkg::PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfc_in_if.sink     item,
    sfc_out_if.source  result
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 2;   // plane distance
    localparam int GW = 2 * W + 3;   // camera dot product sum
    localparam int LW = 2 * W + 4;   // squared length sum
    localparam int RW = 2 * W - 2;   // squared radius

    // Stored frustum and camera.
    logic signed [W-1:0] plane_a_reg [PLANE_COUNT];
    logic signed [W-1:0] plane_b_reg [PLANE_COUNT];
    logic signed [W-1:0] plane_c_reg [PLANE_COUNT];
    logic signed [W-1:0] plane_d_reg [PLANE_COUNT];
    logic signed [W-1:0] cam_pos_reg [3];
    logic signed [W-1:0] cam_fwd_reg [3];

    logic en, accept;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    logic [sfc_pkg::OP_WIDTH-1:0] s1_op_reg, s2_op_reg, s3_op_reg;
    logic [W-2:0]                 s1_r_reg;
    logic signed [W:0]            s1_v_reg   [3];
    logic signed [W-1:0]          s1_fwd_reg [3];

    logic signed [DW-1:0]  s2_rp_reg, s2_rn_reg;
    logic signed [2*W:0]   s2_vf_reg [3];
    logic signed [2*W+1:0] s2_vv_reg [3];
    logic [RW-1:0]         s2_rsq_reg;

    logic signed [GW-1:0]  s3_dot_reg;
    logic [LW-1:0]         s3_len2_reg;
    logic [RW-1:0]         s3_rsq_reg;

    logic [sfc_pkg::VERDICT_WIDTH-1:0] verdict_reg, verdict_next;
    logic                              is_test_reg, is_test_next;

    sfc_pkg::plane_flags_t lane_flags [PLANE_COUNT];
    logic outside_any, hit_any, neg_any, behind_far;

    assign en          = !(out_valid_reg && !result.ready);
    assign item.ready  = en;
    assign accept      = item.valid && en;

    // State updates happen at accept, so every later word sees them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_a_reg[p] <= '0;
                plane_b_reg[p] <= '0;
                plane_c_reg[p] <= '0;
                plane_d_reg[p] <= '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                cam_pos_reg[k] <= '0;
                cam_fwd_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                if (item.operation == sfc_pkg::OP_LOAD_PLANE
                    && 32'(item.plane_index) == 32'(p))
                begin
                    plane_a_reg[p] <= item.coef_a;
                    plane_b_reg[p] <= item.coef_b;
                    plane_c_reg[p] <= item.coef_c;
                    plane_d_reg[p] <= item.coef_d;
                end
            end
            if (item.operation == sfc_pkg::OP_LOAD_CAMERA)
            begin
                cam_fwd_reg[0] <= item.coef_a;
                cam_fwd_reg[1] <= item.coef_b;
                cam_fwd_reg[2] <= item.coef_c;
                cam_pos_reg[0] <= item.pos_x;
                cam_pos_reg[1] <= item.pos_y;
                cam_pos_reg[2] <= item.pos_z;
            end
        end
    end

    // Valid bits travel with the data; everything advances together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= item.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    genvar gp;
    generate
        for (gp = 0; gp < PLANE_COUNT; gp++)
        begin : g_lane
            sfc_plane_lane #(
                .COORD_WIDTH (COORD_WIDTH)
            ) u_lane (
                .clk   (clk),
                .en    (en),
                .a     (plane_a_reg[gp]),
                .b     (plane_b_reg[gp]),
                .c     (plane_c_reg[gp]),
                .d     (plane_d_reg[gp]),
                .px    (item.pos_x),
                .py    (item.pos_y),
                .pz    (item.pos_z),
                .rp    (s2_rp_reg),
                .rn    (s2_rn_reg),
                .flags (lane_flags[gp])
            );
        end
    endgenerate

    // Camera check and radius path, aligned with the lanes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= item.operation;
            s1_r_reg  <= item.radius;
            s1_v_reg[0] <= (W+1)'(item.pos_x) - (W+1)'(cam_pos_reg[0]);
            s1_v_reg[1] <= (W+1)'(item.pos_y) - (W+1)'(cam_pos_reg[1]);
            s1_v_reg[2] <= (W+1)'(item.pos_z) - (W+1)'(cam_pos_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                s1_fwd_reg[k] <= cam_fwd_reg[k];
            end

            s2_op_reg  <= s1_op_reg;
            s2_rp_reg  <= DW'(s1_r_reg) <<< sfc_pkg::FRAC_BITS;
            s2_rn_reg  <= -(DW'(s1_r_reg) <<< sfc_pkg::FRAC_BITS);
            s2_rsq_reg <= RW'(s1_r_reg) * RW'(s1_r_reg);
            for (int k = 0; k < 3; k++)
            begin
                s2_vf_reg[k] <= s1_v_reg[k] * s1_fwd_reg[k];
                s2_vv_reg[k] <= s1_v_reg[k] * s1_v_reg[k];
            end

            s3_op_reg   <= s2_op_reg;
            s3_rsq_reg  <= s2_rsq_reg;
            s3_dot_reg  <= GW'(s2_vf_reg[0]) + GW'(s2_vf_reg[1]) + GW'(s2_vf_reg[2]);
            s3_len2_reg <= LW'(s2_vv_reg[0]) + LW'(s2_vv_reg[1]) + LW'(s2_vv_reg[2]);

            verdict_reg <= verdict_next;
            is_test_reg <= is_test_next;
        end
    end

    always_comb
    begin
        outside_any = 1'b0;
        hit_any     = 1'b0;
        neg_any     = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            outside_any = outside_any | lane_flags[p].below;
            hit_any     = hit_any | lane_flags[p].band;
            neg_any     = neg_any | lane_flags[p].neg;
        end
        // Behind the camera and farther away than the radius.
        behind_far = s3_dot_reg[GW-1] && (LW'(s3_rsq_reg) < s3_len2_reg);

        verdict_next = sfc_pkg::V_INSIDE;
        is_test_next = 1'b0;
        case (s3_op_reg)
            sfc_pkg::OP_SPHERE:
            begin
                is_test_next = 1'b1;
                if (outside_any)
                    verdict_next = sfc_pkg::V_OUTSIDE;
                else if (hit_any)
                    verdict_next = sfc_pkg::V_INTERSECT;
            end
            sfc_pkg::OP_POINT:
            begin
                is_test_next = 1'b1;
                if (neg_any)
                    verdict_next = sfc_pkg::V_OUTSIDE;
            end
            sfc_pkg::OP_GEOMETRY:
            begin
                is_test_next = 1'b1;
                if (behind_far || outside_any)
                    verdict_next = sfc_pkg::V_OUTSIDE;
                else if (hit_any)
                    verdict_next = sfc_pkg::V_INTERSECT;
            end
            default:
            begin
                verdict_next = sfc_pkg::V_INSIDE;
                is_test_next = 1'b0;
            end
        endcase
    end

    assign result.valid          = out_valid_reg;
    assign result.verdict        = verdict_reg;
    assign result.is_test_result = is_test_reg;

`ifndef ASSERT_OFF
    a_load_inside: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.is_test_result |-> result.verdict == sfc_pkg::V_INSIDE)
        else $error("load word returned a nonzero verdict");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.verdict == sfc_pkg::V_INSIDE
                          || result.verdict == sfc_pkg::V_INTERSECT
                          || result.verdict == sfc_pkg::V_OUTSIDE))
        else $error("verdict code out of range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word did not enter the pipeline");

    a_last_stage_out: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && en |=> result.valid)
        else $error("word lost between last stage and output");

    a_camera_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.operation == sfc_pkg::OP_LOAD_CAMERA
        |=> cam_pos_reg[0] == $past(item.pos_x))
        else $error("camera load not stored");
`endif

endmodule

`default_nettype wire

### design/sfc_plane_lane.sv
// One plane lane: three products, exact distance sum, compare against radius.
// Three register stages; depends on sfc_pkg for the flag type and fraction bits.
`default_nettype none

module sfc_plane_lane #(
    parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [COORD_WIDTH-1:0]     a,
    input  wire logic signed [COORD_WIDTH-1:0]     b,
    input  wire logic signed [COORD_WIDTH-1:0]     c,
    input  wire logic signed [COORD_WIDTH-1:0]     d,
    input  wire logic signed [COORD_WIDTH-1:0]     px,
    input  wire logic signed [COORD_WIDTH-1:0]     py,
    input  wire logic signed [COORD_WIDTH-1:0]     pz,
    input  wire logic signed [2*COORD_WIDTH+1:0]   rp,
    input  wire logic signed [2*COORD_WIDTH+1:0]   rn,
    output sfc_pkg::plane_flags_t                  flags
);
    localparam int PW = 2 * COORD_WIDTH;
    localparam int DW = 2 * COORD_WIDTH + 2;

    logic signed [PW-1:0]          prod_a_reg, prod_b_reg, prod_c_reg;
    logic signed [PW-1:0]          prod_a_next, prod_b_next, prod_c_next;
    logic signed [COORD_WIDTH-1:0] d_reg;
    logic signed [DW-1:0]          dist_reg, dist_next;
    sfc_pkg::plane_flags_t         flags_reg, flags_next;

    always_comb
    begin
        prod_a_next = a * px;
        prod_b_next = b * py;
        prod_c_next = c * pz;
        dist_next   = (DW'(d_reg) <<< sfc_pkg::FRAC_BITS) + DW'(prod_a_reg)
                      + DW'(prod_b_reg) + DW'(prod_c_reg);
        flags_next.below = dist_reg < rn;
        flags_next.band  = (rn < dist_reg) && (dist_reg < rp);
        flags_next.neg   = dist_reg[DW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            prod_c_reg <= prod_c_next;
            d_reg      <= d;
            dist_reg   <= dist_next;
            flags_reg  <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire
